// ===== rtl/core/wvm_pkg.sv =====
// ---------------------------------------------------------------------------
// wvm_pkg
// Shared constants, opcodes and register indexes for the voice mixer.
// ---------------------------------------------------------------------------
package wvm_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int ENV_STEP_DEF    = 100;

    localparam int LEN_W  = 13;
    localparam int DS_W   = 8;
    localparam int VAL_W  = 16;
    localparam int KEY_W  = 7;
    localparam int OP_W   = 3;
    localparam int TIME_W = 32;
    localparam int ADDR_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_WR_OSC1 = 3'd1,
        OP_WR_OSC2 = 3'd2,
        OP_WR_LFO  = 3'd3,
        OP_WR_AD   = 3'd4,
        OP_WR_REL  = 3'd5,
        OP_PRESS   = 3'd6,
        OP_RELEASE = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        REG_OSC2_LEN = 3'd0,
        REG_LFO_LEN  = 3'd1,
        REG_LFO_DS   = 3'd2,
        REG_AD_LEN   = 3'd3,
        REG_REL_LEN  = 3'd4,
        REG_LFO_EN   = 3'd5,
        REG_SYNC_EN  = 3'd6
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV1,
        ST_DIV2,
        ST_DIV3,
        ST_DIV4,
        ST_ENV,
        ST_READ,
        ST_WAIT,
        ST_MUL1,
        ST_MUL2,
        ST_OUT
    } state_t;

    // which envelope source a tick uses
    typedef enum logic [1:0] {
        ENV_OFF = 2'd0,
        ENV_REL = 2'd1,
        ENV_AD  = 2'd2,
        ENV_SUS = 2'd3
    } env_mode_t;

    // configuration bundle handed to the datapath
    typedef struct packed {
        logic [LEN_W-1:0] osc2_length;
        logic [LEN_W-1:0] lfo_length;
        logic [DS_W-1:0]  lfo_downsample;
        logic [LEN_W-1:0] attack_decay_length;
        logic [LEN_W-1:0] release_length;
        logic             lfo_enable;
        logic             sync_enable;
    } cfg_t;

endpackage

// ===== rtl/core/wvm_ram.sv =====
// ---------------------------------------------------------------------------
// wvm_ram
// Generic single-port-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module wvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/wvm_divider.sv =====
// ---------------------------------------------------------------------------
// wvm_divider
// Radix-2 restoring divider, 32-bit dividend by 13-bit divisor, one bit
// per cycle. Gives quotient and remainder.
// ---------------------------------------------------------------------------
module wvm_divider
    import wvm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TIME_W-1:0] dividend,
    input  logic [LEN_W-1:0]  divisor,
    output logic              done,
    output logic [TIME_W-1:0] quotient,
    output logic [LEN_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(TIME_W + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [TIME_W-1:0] q_reg, q_next;
    logic [LEN_W-1:0]  r_reg, r_next;
    logic [LEN_W-1:0]  d_reg, d_next;
    logic [LEN_W:0]    trial;
    logic [TIME_W-1:0] step_q;
    logic [LEN_W-1:0]  step_r;

    // one restoring step from the current partial result
    always_comb
    begin
        trial = {r_reg, q_reg[TIME_W-1]};
        if (trial >= {1'b0, d_reg})
        begin
            step_r = LEN_W'(trial - {1'b0, d_reg});
            step_q = {q_reg[TIME_W-2:0], 1'b1};
        end
        else
        begin
            step_r = trial[LEN_W-1:0];
            step_q = {q_reg[TIME_W-2:0], 1'b0};
        end
    end

    // load on start, otherwise shift in one dividend bit while busy
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(TIME_W);
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            q_next   = step_q;
            r_next   = step_r;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    // result of the last step, valid while done is high
    assign done      = busy_reg && (cnt_reg == CNT_W'(1));
    assign quotient  = step_q;
    assign remainder = step_r;

endmodule

// ===== rtl/core/wvm_regs.sv =====
// ---------------------------------------------------------------------------
// wvm_regs
// APB configuration register file.
// ---------------------------------------------------------------------------
module wvm_regs
    import wvm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg, cfg_next;
    logic [2:0] widx;

    assign widx   = paddr[ADDR_W-1:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            case (widx)
                REG_OSC2_LEN: cfg_next.osc2_length         = pwdata[LEN_W-1:0];
                REG_LFO_LEN:  cfg_next.lfo_length          = pwdata[LEN_W-1:0];
                REG_LFO_DS:   cfg_next.lfo_downsample      = pwdata[DS_W-1:0];
                REG_AD_LEN:   cfg_next.attack_decay_length = pwdata[LEN_W-1:0];
                REG_REL_LEN:  cfg_next.release_length      = pwdata[LEN_W-1:0];
                REG_LFO_EN:   cfg_next.lfo_enable          = pwdata[0];
                REG_SYNC_EN:  cfg_next.sync_enable         = pwdata[0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
        begin
            case (widx)
                REG_OSC2_LEN: prdata = 32'(cfg_reg.osc2_length);
                REG_LFO_LEN:  prdata = 32'(cfg_reg.lfo_length);
                REG_LFO_DS:   prdata = 32'(cfg_reg.lfo_downsample);
                REG_AD_LEN:   prdata = 32'(cfg_reg.attack_decay_length);
                REG_REL_LEN:  prdata = 32'(cfg_reg.release_length);
                REG_LFO_EN:   prdata = 32'(cfg_reg.lfo_enable);
                REG_SYNC_EN:  prdata = 32'(cfg_reg.sync_enable);
                default:      prdata = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.osc2_length         <= LEN_W'(1);
            cfg_reg.lfo_length          <= LEN_W'(1);
            cfg_reg.lfo_downsample      <= DS_W'(100);
            cfg_reg.attack_decay_length <= LEN_W'(1);
            cfg_reg.release_length      <= '0;
            cfg_reg.lfo_enable          <= 1'b0;
            cfg_reg.sync_enable         <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/wavetable_voice_mixer.sv =====
// ---------------------------------------------------------------------------
// wavetable_voice_mixer
// One wavetable voice: two oscillators, LFO, ADSR envelope from tables.
// ---------------------------------------------------------------------------
// Table writes, key press and key release are accepted one per cycle while no
// tick is in progress. A tick runs four passes of the shared divider (osc1 phase,
// osc2 phase, LFO step, LFO phase), then envelope step, table read, read wait,
// two multiply stages and output. The next request is taken as the sample turns
// valid; a stalled sample holds the following tick in its last multiply stage.
// Reset is asynchronous; tables hold no reset value and need no clearing.
module wavetable_voice_mixer
    import wvm_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int ENV_STEP    = ENV_STEP_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [OP_W-1:0]         opcode,
    input  logic [LEN_W-1:0]        index,
    input  logic signed [VAL_W-1:0] value,
    input  logic [KEY_W-1:0]        key,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [VAL_W-1:0] sample
);

    localparam int TA_W = $clog2(TABLE_DEPTH);
    localparam logic [LEN_W:0] DEPTH_L = (LEN_W+1)'(TABLE_DEPTH);

    // envelope step by reciprocal multiply; exact for offsets below 2^23
    localparam int ENV_SH = 23 + $clog2(ENV_STEP);
    localparam logic [24:0] ENV_RECIP =
        25'(((64'd1 << ENV_SH) + 64'(ENV_STEP) - 64'd1) / 64'(ENV_STEP));

    cfg_t cfg;

    wvm_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    // control and voice state
    state_t            state_reg, state_next;
    logic [TIME_W-1:0] count_reg, count_next;
    logic [TIME_W-1:0] trig_reg, trig_next;
    logic [TIME_W-1:0] rel_reg, rel_next;
    logic [KEY_W-1:0]  held_reg, held_next;
    logic [LEN_W-1:0]  len1_reg, len1_next;
    logic              out_valid_reg, out_valid_next;

    // tick scratch
    logic [LEN_W-1:0]        ph1_reg, ph1_next;
    logic [LEN_W-1:0]        a2_reg, a2_next;
    logic [LEN_W-1:0]        la_reg, la_next;
    logic [TIME_W-1:0]       eidx_reg, eidx_next;
    env_mode_t               emode_reg, emode_next;
    logic [TIME_W-1:0]       e_reg, e_next;
    logic [LEN_W-1:0]        ea_reg, ea_next;
    logic signed [33:0]      p1_reg, p1_next;
    logic signed [VAL_W-1:0] sample_reg, sample_next;

    // divider
    logic              div_start, div_done;
    logic [TIME_W-1:0] div_a, div_q;
    logic [LEN_W-1:0]  div_b, div_r;

    wvm_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
        .divisor(div_b), .done(div_done), .quotient(div_q), .remainder(div_r)
    );

    // table memories
    logic [4:0]      we;
    logic [TA_W-1:0] ra [5];
    logic [VAL_W-1:0] rd [5];
    logic            wr_ok;

    assign wr_ok = ({1'b0, index} < DEPTH_L);

    genvar g;
    generate
        for (g = 0; g < 5; g++)
        begin : g_tab
            wvm_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_ram (
                .clk(clk), .we(we[g]), .waddr(index[TA_W-1:0]),
                .wdata(value), .raddr(ra[g]), .rdata(rd[g])
            );
        end
    endgenerate

    // out-of-range read flags captured with the read
    logic [4:0] oor_reg, oor_next;
    logic [LEN_W-1:0] ea_sel;

    function automatic logic [LEN_W-1:0] nz(input logic [LEN_W-1:0] v);
        return (v == '0) ? LEN_W'(1) : v;
    endfunction

    // a waiting sample sits in the output register and does not block input
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    assign ea_sel = (emode_reg == ENV_SUS) ? (cfg.attack_decay_length - 1'b1) : ea_reg;

    // table read indexes for both oscillators, LFO and both envelope tables
    always_comb
    begin
        ra[0] = ph1_reg[TA_W-1:0];
        ra[1] = a2_reg[TA_W-1:0];
        ra[2] = la_reg[TA_W-1:0];
        ra[3] = ea_sel[TA_W-1:0];
        ra[4] = ea_reg[TA_W-1:0];
    end

    // sequencer
    always_comb
    begin
        logic signed [VAL_W:0]   sum;
        logic signed [VAL_W-1:0] lfo;
        logic [VAL_W-1:0]        env;
        logic signed [51:0]      prod;
        logic signed [51:0]      adj;
        logic signed [22:0]      r;
        logic [LEN_W-1:0]        elen;
        logic [23:0]             win;
        logic [47:0]             eprod;
        logic [LEN_W-1:0]        eq;

        state_next     = state_reg;
        count_next     = count_reg;
        trig_next      = trig_reg;
        rel_next       = rel_reg;
        held_next      = held_reg;
        len1_next      = len1_reg;
        out_valid_next = out_valid_reg;
        ph1_next       = ph1_reg;
        a2_next        = a2_reg;
        la_next        = la_reg;
        eidx_next      = eidx_reg;
        emode_next     = emode_reg;
        e_next         = e_reg;
        ea_next        = ea_reg;
        oor_next       = oor_reg;
        p1_next        = p1_reg;
        sample_next    = sample_reg;
        div_start      = 1'b0;
        div_a          = count_reg;
        div_b          = nz(len1_reg);
        we             = '0;
        sum            = '0;
        lfo            = '0;
        env            = '0;
        prod           = '0;
        adj            = '0;
        r              = '0;
        elen           = '0;
        win            = '0;
        eprod          = '0;
        eq             = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (op_t'(opcode))
                        OP_WR_OSC1: we[0] = wr_ok;
                        OP_WR_OSC2: we[1] = wr_ok;
                        OP_WR_LFO:  we[2] = wr_ok;
                        OP_WR_AD:   we[3] = wr_ok;
                        OP_WR_REL:  we[4] = wr_ok;
                        OP_PRESS:
                        begin
                            held_next = key;
                            len1_next = index;
                            trig_next = count_reg;
                            rel_next  = '1;
                        end
                        OP_RELEASE:
                        begin
                            if (key == held_reg)
                            begin
                                rel_next = count_reg;
                            end
                        end
                        OP_TICK:
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV1;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            // phase of oscillator 1
            ST_DIV1:
            begin
                if (div_done)
                begin
                    ph1_next   = div_r;
                    div_start  = 1'b1;
                    div_a      = cfg.sync_enable ? TIME_W'(div_r) : count_reg;
                    div_b      = nz(cfg.osc2_length);
                    state_next = ST_DIV2;
                end
            end
            // oscillator 2 address
            ST_DIV2:
            begin
                if (div_done)
                begin
                    a2_next    = div_r;
                    div_start  = 1'b1;
                    div_a      = count_reg;
                    div_b      = (cfg.lfo_downsample == '0) ? LEN_W'(1)
                                 : LEN_W'(cfg.lfo_downsample);
                    state_next = ST_DIV3;
                end
            end
            // LFO step count
            ST_DIV3:
            begin
                if (div_done)
                begin
                    div_start  = 1'b1;
                    div_a      = div_q;
                    div_b      = nz(cfg.lfo_length);
                    state_next = ST_DIV4;
                end
            end
            // LFO address, then envelope offset
            ST_DIV4:
            begin
                if (div_done)
                begin
                    la_next = div_r;
                    if (count_reg > rel_reg)
                    begin
                        emode_next = ENV_REL;
                        e_next     = count_reg - rel_reg;
                    end
                    else if (count_reg > trig_reg)
                    begin
                        emode_next = ENV_AD;
                        e_next     = count_reg - trig_reg;
                    end
                    else
                    begin
                        emode_next = ENV_OFF;
                        e_next     = '0;
                    end
                    state_next = ST_ENV;
                end
            end
            // envelope step index; compare offset with the window
            ST_ENV:
            begin
                elen      = (emode_reg == ENV_REL) ? cfg.release_length
                            : cfg.attack_decay_length;
                win       = 24'(elen) * 24'(ENV_STEP);
                eprod     = 48'(e_reg[22:0]) * 48'(ENV_RECIP);
                eq        = LEN_W'(eprod >> ENV_SH);
                eidx_next = TIME_W'(eq);
                ea_next   = eq;
                if (emode_reg == ENV_REL)
                begin
                    if (e_reg >= TIME_W'(win))
                    begin
                        emode_next = ENV_OFF;
                    end
                end
                else if (emode_reg == ENV_AD)
                begin
                    if (cfg.attack_decay_length == '0)
                    begin
                        emode_next = ENV_OFF;
                    end
                    else if (e_reg >= TIME_W'(win))
                    begin
                        emode_next = ENV_SUS;
                    end
                end
                state_next = ST_READ;
            end
            ST_READ:
            begin
                oor_next[0] = ({1'b0, ph1_reg} >= DEPTH_L);
                oor_next[1] = ({1'b0, a2_reg} >= DEPTH_L);
                oor_next[2] = ({1'b0, la_reg} >= DEPTH_L);
                oor_next[3] = ({1'b0, ea_sel} >= DEPTH_L) ||
                              ((emode_reg == ENV_AD) && (eidx_reg >= TIME_W'(TABLE_DEPTH)));
                oor_next[4] = (eidx_reg >= TIME_W'(TABLE_DEPTH));
                state_next  = ST_WAIT;
            end
            ST_WAIT:
            begin
                state_next = ST_MUL1;
            end
            // env * sum
            ST_MUL1:
            begin
                sum = (oor_reg[0] ? 17'sd0 : (VAL_W+1)'(signed'(rd[0])))
                    + (oor_reg[1] ? 17'sd0 : (VAL_W+1)'(signed'(rd[1])));
                case (emode_reg)
                    ENV_REL: env = oor_reg[4] ? '0 : rd[4];
                    ENV_AD,
                    ENV_SUS: env = oor_reg[3] ? '0 : rd[3];
                    default: env = '0;
                endcase
                p1_next    = $signed({1'b0, env}) * sum;
                state_next = ST_MUL2;
            end
            // times lfo, scale, saturate; wait here while the output is full
            ST_MUL2:
            begin
                if (cfg.lfo_enable)
                begin
                    lfo = oor_reg[2] ? '0 : signed'(rd[2]);
                end
                else
                begin
                    lfo = 16'sd16384;
                end
                prod = p1_reg * lfo;
                adj  = prod + (prod[51] ? 52'sd536870911 : 52'sd0);
                r    = adj[51:29];
                if (!out_valid_reg || out_ready)
                begin
                    if (r > 23'sd32767)
                    begin
                        sample_next = 16'sh7fff;
                    end
                    else if (r < -23'sd32768)
                    begin
                        sample_next = 16'sh8000;
                    end
                    else
                    begin
                        sample_next = r[15:0];
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    count_next     = count_reg + 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            trig_reg      <= '1;
            rel_reg       <= '1;
            held_reg      <= '0;
            len1_reg      <= LEN_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            trig_reg      <= trig_next;
            rel_reg       <= rel_next;
            held_reg      <= held_next;
            len1_reg      <= len1_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ph1_reg    <= ph1_next;
        a2_reg     <= a2_next;
        la_reg     <= la_next;
        eidx_reg   <= eidx_next;
        emode_reg  <= emode_next;
        e_reg      <= e_next;
        ea_reg     <= ea_next;
        oor_reg    <= oor_next;
        p1_reg     <= p1_next;
        sample_reg <= sample_next;
    end

endmodule
